// ----- rtl/pbcvu_pkg.sv -----
// ----------------------------------------------------------------------------
// pbcvu_pkg
// Types and constants shared by the box clamp and velocity update unit.
// ----------------------------------------------------------------------------
package pbcvu_pkg;

   // configuration register indexes
   localparam logic [2:0] CsrBoxMinX   = 3'd0;
   localparam logic [2:0] CsrBoxMinY   = 3'd1;
   localparam logic [2:0] CsrBoxMaxX   = 3'd2;
   localparam logic [2:0] CsrBoxMaxY   = 3'd3;
   localparam logic [2:0] CsrInvDt     = 3'd4;
   localparam logic [2:0] CsrMaxSpeed  = 3'd5;

   // ceil(2^37 / 5), exact division by five for operands below 2^34
   localparam logic [34:0] RecipFive  = 35'd27487790695;
   localparam int          RecipShift = 37;

   localparam logic [31:0] SatMax = 32'h7fff_ffff;
   localparam logic [31:0] SatMin = 32'h8000_0000;

   // pipeline depth bookkeeping
   localparam int RootSteps = 32;
   localparam int DivSteps  = 32;

   typedef struct packed {
      logic [1:0][31:0] pos;
      logic [1:0][31:0] vel;
      logic [1:0][31:0] mag;
      logic [1:0]       hit;
      logic             lim;
   } side_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [63:0] root;
   } root_type;

   typedef struct packed {
      logic [1:0][31:0] rem;
      logic [1:0][31:0] quo;
      logic [1:0][31:0] low;
   } div_type;

endpackage

// ----- rtl/particle_box_clamp_velocity_update_unit.sv -----
// ----------------------------------------------------------------------------
// particle_box_clamp_velocity_update_unit
// Box wall push back, velocity from displacement and speed limit, Q16.16.
//
//   channel  dir  beat contents
//   req_     in   tdata: old_x, old_y, pred_x, pred_y
//   rsp_     out  tdata: new_x, new_y, vel_x, vel_y; tuser: wall_hit, speed_limited
//   csr_     in   register index and write data, no read back
//
// one beat per cycle sustained while results are taken; the pipeline depth is set by the 32 step square
// root pipeline and the 32 step divider pipeline.
// reset clears valid bits and loads register defaults.
// a held result stalls the whole pipeline until taken; nothing is lost.
// ----------------------------------------------------------------------------
module particle_box_clamp_velocity_update_unit
   import pbcvu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // old_x, old_y, pred_x, pred_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // new_x, new_y, vel_x, vel_y
   output logic [2:0]   rsp_tuser,   // wall_hit[1:0], speed_limited
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int StA   = 0;
   localparam int StH   = 7;
   localparam int StRt  = StH + RootSteps;
   localparam int StM   = StRt + 1;
   localparam int StN   = StM + 1;
   localparam int StDv  = StN + DivSteps;
   localparam int Depth = StDv + 2;

   logic [1:0][31:0] box_min_ff, box_max_ff;
   logic [30:0]      inv_dt_ff, max_speed_ff;
   logic [Depth-1:0] valid_ff;
   logic             en;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff   <= '0;
         box_max_ff   <= {32'd6553600, 32'd6553600};
         inv_dt_ff    <= 31'd3932160;
         max_speed_ff <= 31'd32768000;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrBoxMinX:  box_min_ff[0] <= csr_wdata;
            CsrBoxMinY:  box_min_ff[1] <= csr_wdata;
            CsrBoxMaxX:  box_max_ff[0] <= csr_wdata;
            CsrBoxMaxY:  box_max_ff[1] <= csr_wdata;
            CsrInvDt:    inv_dt_ff     <= csr_wdata[30:0];
            CsrMaxSpeed: max_speed_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign en         = !valid_ff[Depth-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Depth-2:0], req_tvalid};
      end
   end

   // stage a: wall test, penetration plus two
   logic [1:0][31:0] a_pred_ff, a_old_ff;
   logic [1:0][33:0] a_x_ff;
   logic [1:0]       a_dn_ff, a_hit_ff;
   // stage b: partial products for the divide by five
   logic [1:0][31:0] b_pred_ff, b_old_ff;
   logic [1:0][33:0] b_x_ff;
   logic [1:0][51:0] b_pph_ff, b_ppl_ff;
   logic [1:0]       b_dn_ff, b_hit_ff;
   // stage c: push distance
   logic [1:0][31:0] c_pred_ff, c_old_ff;
   logic [1:0][34:0] c_push_ff;
   logic [1:0]       c_dn_ff, c_hit_ff;
   // stage d: corrected position and displacement
   logic [1:0][31:0] d_new_ff;
   logic [1:0][32:0] d_mag_ff;
   logic [1:0]       d_neg_ff, d_hit_ff;
   // stage e: velocity partial products
   logic [1:0][31:0] e_new_ff;
   logic [1:0][47:0] e_pl_ff, e_ph_ff;
   logic [1:0]       e_neg_ff, e_hit_ff;
   // stage f: rounded, saturated velocity
   side_type         f_side_ff;
   // stage g: squares
   side_type         g_side_ff;
   logic [1:0][63:0] g_sq_ff;
   logic [61:0]      g_ms2_ff;
   // square root pipeline, entry 0 is stage h
   root_type         rt_ff   [0:RootSteps];
   side_type         rt_side_ff [0:RootSteps];
   side_type         rt_side_in;
   // numerators
   side_type         m_side_ff;
   logic [1:0][62:0] m_prod_ff;
   logic [31:0]      m_len_ff;
   // divider pipeline, entry 0 is the setup stage
   div_type          dv_ff   [0:DivSteps];
   side_type         dv_side_ff [0:DivSteps];
   logic [31:0]      dv_len_ff [0:DivSteps];
   // result register
   logic [1:0][31:0] o_pos_ff, o_vel_ff;
   logic [1:0]       o_hit_ff;
   logic             o_lim_ff;

   for (genvar k = 0; k < 2; k++) begin : g_axis
      logic [32:0] pred33, lo33, hi33, pen33, d33;
      logic        below, above;
      logic [68:0] prod69;
      logic [31:0] quot;
      logic [35:0] pred36, pos36;
      logic [31:0] new_in;
      logic [64:0] p65;
      logic [64:0] m65;
      logic [31:0] vel_in, mag_in;

      assign pred33 = {req_tdata[64+32*k+31], req_tdata[64+32*k +: 32]};
      assign lo33   = {box_min_ff[k][31], box_min_ff[k]};
      assign hi33   = {box_max_ff[k][31], box_max_ff[k]};
      assign below  = $signed(pred33) < $signed(lo33);
      assign above  = !below && ($signed(pred33) > $signed(hi33));
      assign pen33  = below ? (lo33 - pred33) : (pred33 - hi33);

      always_ff @(posedge clock) begin
         if (en) begin
            a_pred_ff[k] <= req_tdata[64+32*k +: 32];
            a_old_ff[k]  <= req_tdata[32*k +: 32];
            a_x_ff[k]    <= {1'b0, pen33} + 34'd2;
            a_dn_ff[k]   <= above;
            a_hit_ff[k]  <= below || above;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            b_pred_ff[k] <= a_pred_ff[k];
            b_old_ff[k]  <= a_old_ff[k];
            b_x_ff[k]    <= a_x_ff[k];
            b_pph_ff[k]  <= 52'(a_x_ff[k][33:17]) * 52'(RecipFive);
            b_ppl_ff[k]  <= 52'(a_x_ff[k][16:0]) * 52'(RecipFive);
            b_dn_ff[k]   <= a_dn_ff[k];
            b_hit_ff[k]  <= a_hit_ff[k];
         end
      end

      assign prod69 = {b_pph_ff[k], 17'd0} + 69'(b_ppl_ff[k]);
      assign quot   = prod69[RecipShift +: 32];

      always_ff @(posedge clock) begin
         if (en) begin
            c_pred_ff[k] <= b_pred_ff[k];
            c_old_ff[k]  <= b_old_ff[k];
            c_push_ff[k] <= b_hit_ff[k] ?
                            (35'(b_x_ff[k]) - 35'd2 + 35'(quot)) : 35'd0;
            c_dn_ff[k]   <= b_dn_ff[k];
            c_hit_ff[k]  <= b_hit_ff[k];
         end
      end

      assign pred36 = {{4{c_pred_ff[k][31]}}, c_pred_ff[k]};
      assign pos36  = c_dn_ff[k] ? (pred36 - {1'b0, c_push_ff[k]})
                                 : (pred36 + {1'b0, c_push_ff[k]});
      always_comb begin
         if ($signed(pos36) > $signed({4'd0, SatMax})) begin
            new_in = SatMax;
         end else if ($signed(pos36) < $signed({4'hf, SatMin})) begin
            new_in = SatMin;
         end else begin
            new_in = pos36[31:0];
         end
      end
      assign d33 = {new_in[31], new_in} - {c_old_ff[k][31], c_old_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            d_new_ff[k] <= new_in;
            d_mag_ff[k] <= d33[32] ? (33'd0 - d33) : d33;
            d_neg_ff[k] <= d33[32];
            d_hit_ff[k] <= c_hit_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e_new_ff[k] <= d_new_ff[k];
            e_pl_ff[k]  <= 48'(d_mag_ff[k][16:0]) * 48'(inv_dt_ff);
            e_ph_ff[k]  <= 48'(d_mag_ff[k][32:17]) * 48'(inv_dt_ff);
            e_neg_ff[k] <= d_neg_ff[k];
            e_hit_ff[k] <= d_hit_ff[k];
         end
      end

      assign p65 = {e_ph_ff[k], 17'd0} + 65'(e_pl_ff[k]) + (65'd1 << (FRAC_BITS - 1));
      assign m65 = p65 >> FRAC_BITS;
      always_comb begin
         if (!e_neg_ff[k] && (m65 > 65'(SatMax))) begin
            mag_in = SatMax;
         end else if (e_neg_ff[k] && (m65 > 65'(SatMin))) begin
            mag_in = SatMin;
         end else begin
            mag_in = m65[31:0];
         end
         vel_in = e_neg_ff[k] ? (32'd0 - mag_in) : mag_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            f_side_ff.pos[k] <= e_new_ff[k];
            f_side_ff.vel[k] <= vel_in;
            f_side_ff.mag[k] <= mag_in;
            f_side_ff.hit[k] <= e_hit_ff[k];
            g_sq_ff[k]       <= 64'(f_side_ff.mag[k]) * 64'(f_side_ff.mag[k]);
            m_prod_ff[k]     <= 63'(rt_side_ff[RootSteps].mag[k]) * 63'(max_speed_ff);
         end
      end
   end

   always_comb begin
      rt_side_in     = g_side_ff;
      rt_side_in.lim = (g_sq_ff[0] + g_sq_ff[1]) > 64'(g_ms2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_side_ff.lim <= 1'b0;
         g_side_ff     <= f_side_ff;
         g_ms2_ff      <= 62'(max_speed_ff) * 62'(max_speed_ff);
         rt_ff[0].rad  <= g_sq_ff[0] + g_sq_ff[1];
         rt_ff[0].root <= '0;
         rt_side_ff[0] <= rt_side_in;
      end
   end

   for (genvar i = 1; i <= RootSteps; i++) begin : g_root
      localparam logic [63:0] BitC = 64'd1 << (62 - 2 * (i - 1));
      logic [63:0] trial;
      assign trial = rt_ff[i-1].root + BitC;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rt_ff[i-1].rad >= trial) begin
               rt_ff[i].rad  <= rt_ff[i-1].rad - trial;
               rt_ff[i].root <= (rt_ff[i-1].root >> 1) + BitC;
            end else begin
               rt_ff[i].rad  <= rt_ff[i-1].rad;
               rt_ff[i].root <= rt_ff[i-1].root >> 1;
            end
            rt_side_ff[i] <= rt_side_ff[i-1];
         end
      end
   end

   logic [1:0][62:0] num_in;
   assign num_in[0] = m_prod_ff[0] + 63'(m_len_ff >> 1);
   assign num_in[1] = m_prod_ff[1] + 63'(m_len_ff >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         m_side_ff     <= rt_side_ff[RootSteps];
         m_len_ff      <= rt_ff[RootSteps].root[31:0];
         dv_side_ff[0] <= m_side_ff;
         dv_len_ff[0]  <= m_len_ff;
         dv_ff[0].rem  <= {{1'b0, num_in[1][62:32]}, {1'b0, num_in[0][62:32]}};
         dv_ff[0].quo  <= '0;
         dv_ff[0].low  <= {num_in[1][31:0], num_in[0][31:0]};
      end
   end

   for (genvar j = 1; j <= DivSteps; j++) begin : g_div
      for (genvar k = 0; k < 2; k++) begin : g_lane
         logic [32:0] part;
         logic        take;
         assign part = {dv_ff[j-1].rem[k], dv_ff[j-1].low[k][DivSteps-j]};
         assign take = part >= {1'b0, dv_len_ff[j-1]};
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[j].rem[k] <= take ? 32'(part - {1'b0, dv_len_ff[j-1]})
                                       : part[31:0];
               dv_ff[j].quo[k] <= {dv_ff[j-1].quo[k][30:0], take};
               dv_ff[j].low[k] <= dv_ff[j-1].low[k];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
            dv_len_ff[j]  <= dv_len_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_out
      logic [31:0] lim_vel;
      assign lim_vel = dv_side_ff[DivSteps].vel[k][31] ?
                       (32'd0 - dv_ff[DivSteps].quo[k]) : dv_ff[DivSteps].quo[k];
      always_ff @(posedge clock) begin
         if (en) begin
            o_pos_ff[k] <= dv_side_ff[DivSteps].pos[k];
            o_vel_ff[k] <= dv_side_ff[DivSteps].lim ? lim_vel
                                                     : dv_side_ff[DivSteps].vel[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_hit_ff <= dv_side_ff[DivSteps].hit;
         o_lim_ff <= dv_side_ff[DivSteps].lim;
      end
   end

   assign rsp_tdata = {o_vel_ff[1], o_vel_ff[0], o_pos_ff[1], o_pos_ff[0]};
   assign rsp_tuser = {o_lim_ff, o_hit_ff};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[StRt] |-> rt_ff[RootSteps].rad <= (rt_ff[RootSteps].root << 1))
      else $error("square root remainder out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[StDv] && dv_side_ff[DivSteps].lim) |->
      (dv_ff[DivSteps].rem[0] < dv_len_ff[DivSteps] &&
       dv_ff[DivSteps].rem[1] < dv_len_ff[DivSteps]))
      else $error("divider remainder not below divisor");

   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[StA])
      else $error("accepted beat not in first stage");

endmodule
